FILE: hdl/dhcpp_pkg.sv
// dhcpp_pkg: shared types and constants for the dhcp reply option parser
// holds word structs, parse state and protocol codes; depends on nothing

package dhcpp_pkg;

  // protocol constants
  localparam logic [15:0] SERVER_UDP_PORT = 16'd67;
  localparam logic [7:0]  OP_REPLY        = 8'd2;
  localparam logic [31:0] COOKIE_VALUE    = 32'h6382_5363;
  localparam logic [7:0]  YIADDR_FIRST    = 8'd16;
  localparam logic [7:0]  YIADDR_LAST     = 8'd19;
  localparam logic [7:0]  COOKIE_FIRST    = 8'd236;
  localparam logic [7:0]  COOKIE_LAST     = 8'd239;
  localparam logic [7:0]  CAPTURE_BYTES   = 8'd4;

  // option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_SUBNET   = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_LEASE    = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_PORT   = 3'd1;
  localparam logic [2:0] ST_NOT_REPLY  = 3'd2;
  localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
  localparam logic [2:0] ST_MISMATCH   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;

  localparam logic [3:0] EXPECTED_TYPE_RESET = 4'd2;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CODE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4,
    PH_IDLE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] source_port;
    logic [31:0] source_addr;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] offered_ip;
    logic [31:0] netmask;
    logic [31:0] gateway_ip;
    logic [31:0] dns_ip;
    logic [31:0] server_ip;
    logic [31:0] lease_start;
    logic [31:0] lease_end;
  } out_word_t;

  // complete parser state carried between bytes
  typedef struct packed {
    logic [7:0]  byte_offset;
    phase_t      parse_phase;
    logic [7:0]  option_code;
    logic [7:0]  option_remaining;
    logic [7:0]  option_index;
    logic [31:0] collect_shift;
    logic [2:0]  error_code;
    logic [31:0] held_offered_ip;
    logic [31:0] held_subnet;
    logic [31:0] held_gateway;
    logic [31:0] held_dns;
    logic [31:0] held_server;
    logic [31:0] held_lease_start;
    logic [31:0] held_lease_end;
  } parse_state_t;

endpackage

FILE: hdl/dhcpp_step.sv
// dhcpp_step: combinational next-state and result logic for one byte
// depends on dhcpp_pkg

module dhcpp_step (
  input  dhcpp_pkg::parse_state_t state_cur,
  input  dhcpp_pkg::in_word_t     in_word,
  input  logic [3:0]              expected_msg_type,
  output dhcpp_pkg::parse_state_t state_nxt,
  output logic                    emit,
  output dhcpp_pkg::out_word_t    result
);

  dhcpp_pkg::parse_state_t s;
  logic [7:0]  off;
  logic [31:0] shifted;
  logic [7:0]  remaining_dec;

  // next state
  always_comb begin
    s = state_cur;
    if (in_word.first_byte) begin
      s.byte_offset      = '0;
      s.parse_phase      = dhcpp_pkg::PH_HEADER;
      s.option_code      = '0;
      s.option_remaining = '0;
      s.option_index     = '0;
      s.collect_shift    = '0;
      s.error_code       = dhcpp_pkg::ST_OK;
    end

    off           = s.byte_offset;
    shifted       = {s.collect_shift[23:0], in_word.data_byte};
    remaining_dec = s.option_remaining - 8'd1;

    case (s.parse_phase)
      dhcpp_pkg::PH_HEADER: begin
        if (off == 8'd0) begin
          s.held_server = in_word.source_addr;
          if (in_word.source_port != dhcpp_pkg::SERVER_UDP_PORT) begin
            s.error_code  = dhcpp_pkg::ST_BAD_PORT;
            s.parse_phase = dhcpp_pkg::PH_DONE;
          end else if (in_word.data_byte != dhcpp_pkg::OP_REPLY) begin
            s.error_code  = dhcpp_pkg::ST_NOT_REPLY;
            s.parse_phase = dhcpp_pkg::PH_DONE;
          end
        end else if (off inside {[dhcpp_pkg::YIADDR_FIRST:dhcpp_pkg::YIADDR_LAST]}) begin
          s.collect_shift = shifted;
          if (off == dhcpp_pkg::YIADDR_LAST) begin
            s.held_offered_ip = shifted;
          end
        end else if (off >= dhcpp_pkg::COOKIE_FIRST) begin
          s.collect_shift = shifted;
          if (off >= dhcpp_pkg::COOKIE_LAST) begin
            if (shifted != dhcpp_pkg::COOKIE_VALUE) begin
              s.error_code  = dhcpp_pkg::ST_BAD_COOKIE;
              s.parse_phase = dhcpp_pkg::PH_DONE;
            end else begin
              s.parse_phase = dhcpp_pkg::PH_CODE;
            end
          end
        end
        if (s.parse_phase == dhcpp_pkg::PH_HEADER && off < dhcpp_pkg::COOKIE_LAST) begin
          s.byte_offset = off + 8'd1;
        end
      end
      dhcpp_pkg::PH_CODE: begin
        if (in_word.data_byte == dhcpp_pkg::OPT_END) begin
          s.parse_phase = dhcpp_pkg::PH_DONE;
        end else if (in_word.data_byte != dhcpp_pkg::OPT_PAD) begin
          s.option_code = in_word.data_byte;
          s.parse_phase = dhcpp_pkg::PH_LEN;
        end
      end
      dhcpp_pkg::PH_LEN: begin
        s.option_remaining = in_word.data_byte;
        s.option_index     = '0;
        s.collect_shift    = '0;
        s.parse_phase      = (in_word.data_byte == 8'd0) ? dhcpp_pkg::PH_CODE
                                                         : dhcpp_pkg::PH_DATA;
      end
      dhcpp_pkg::PH_DATA: begin
        // only the first value byte of the message-type option is checked
        if (s.option_index == 8'd0 && s.option_code == dhcpp_pkg::OPT_MSG_TYPE &&
            in_word.data_byte != {4'd0, expected_msg_type} &&
            s.error_code == dhcpp_pkg::ST_OK) begin
          s.error_code = dhcpp_pkg::ST_MISMATCH;
        end
        if (s.option_index < dhcpp_pkg::CAPTURE_BYTES) begin
          s.collect_shift = shifted;
        end
        s.option_index     = s.option_index + 8'd1;
        s.option_remaining = remaining_dec;
        if (remaining_dec == 8'd0) begin
          s.parse_phase = dhcpp_pkg::PH_CODE;
          if (s.option_index >= dhcpp_pkg::CAPTURE_BYTES) begin
            case (s.option_code)
              dhcpp_pkg::OPT_SUBNET: s.held_subnet  = s.collect_shift;
              dhcpp_pkg::OPT_ROUTER: s.held_gateway = s.collect_shift;
              dhcpp_pkg::OPT_DNS:    s.held_dns     = s.collect_shift;
              dhcpp_pkg::OPT_LEASE: begin
                s.held_lease_start = in_word.now_seconds;
                s.held_lease_end   = s.collect_shift + in_word.now_seconds;
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase

    // any last byte leaves the parser idle until the next first byte
    state_nxt = s;
    if (in_word.last_byte) begin
      state_nxt.parse_phase = dhcpp_pkg::PH_IDLE;
    end
  end

  // outputs
  always_comb begin
    emit = in_word.last_byte && (s.parse_phase != dhcpp_pkg::PH_IDLE);

    if (s.parse_phase inside {dhcpp_pkg::PH_HEADER, dhcpp_pkg::PH_LEN, dhcpp_pkg::PH_DATA}) begin
      result.status = dhcpp_pkg::ST_TRUNCATED;
    end else begin
      result.status = s.error_code;
    end
    result.offered_ip  = s.held_offered_ip;
    result.netmask     = s.held_subnet;
    result.gateway_ip  = s.held_gateway;
    result.dns_ip      = s.held_dns;
    result.server_ip   = s.held_server;
    result.lease_start = s.held_lease_start;
    result.lease_end   = s.held_lease_end;
  end

endmodule

FILE: hdl/dhcpp_reply_option_parser_core.sv
// a word accepted into the input register passes through the step logic, and any result
// that it produces is written to the output register once that register is free
// throughput: one byte per cycle through the step logic between the input register
// and the output register; stalls only while a result waits
// reset: rst_n synchronous active low; clears parser state, held values, valid flags,
// and sets expected_msg_type to 2
//
// dhcp_reply_option_parser_core: top level, registers and handshake
// depends on dhcpp_pkg and dhcpp_step

module dhcp_reply_option_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dhcpp_pkg::in_word_t  in_word,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output dhcpp_pkg::out_word_t out_word,
  // config write channel, expected message type
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data
);

  // input register
  logic                    stage_valid_r;
  dhcpp_pkg::in_word_t     stage_word_r;

  // parser state and config
  dhcpp_pkg::parse_state_t state_r;
  dhcpp_pkg::parse_state_t state_nxt;
  logic [3:0]              expected_msg_type_r;

  // output register
  logic                    out_valid_r;
  dhcpp_pkg::out_word_t    out_word_r;

  logic                    emit;
  dhcpp_pkg::out_word_t    result;
  logic                    out_free;
  logic                    advance;

  // the output register can take a new word when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = stage_valid_r && out_free;
  // hold the staged byte only while its result slot is blocked
  assign in_stall  = stage_valid_r && !out_free;
  assign cfg_ready = 1'b1;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  dhcpp_step u_step (
    .state_cur         (state_r),
    .in_word           (stage_word_r),
    .expected_msg_type (expected_msg_type_r),
    .state_nxt         (state_nxt),
    .emit              (emit),
    .result            (result)
  );

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_msg_type_r <= dhcpp_pkg::EXPECTED_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expected_msg_type_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      stage_word_r <= in_word;
    end
  end

  // parser state, all fields reset since held values go out in results
  // all zero is header phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // output register, filled only by bytes that end a datagram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_word_r <= result;
    end
  end

  // a stalled input only happens behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stage_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // a staged byte is never dropped while it waits
  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> stage_valid_r)
    else $error("staged byte lost during stall");

  // after emitting a result the parser goes idle until the next datagram
  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> (state_r.parse_phase == dhcpp_pkg::PH_IDLE))
    else $error("parser not idle after result");

  // a result holds a defined status code
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status <= dhcpp_pkg::ST_TRUNCATED))
    else $error("result status out of range");

endmodule
